// ===== rtl/scti_pkg.sv =====
// Shared types, constants and helpers for the staggered cubic time interpolator.
package scti_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int CHANNELS_DEF = 4096;
    localparam int CH_W         = 12;
    localparam int CH_EXT_W     = 17;
    localparam int H_W          = 24;
    localparam int RATE_W       = 18;
    localparam int CNT_W        = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_W        = 18;
    localparam int W_W          = 18;
    localparam int BND_W        = 14;
    localparam int TAPS         = 4;
    localparam int TAP_W        = 2;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(65536);
    localparam logic [CNT_W-1:0]  X_RESET    = CNT_W'(256);
    localparam logic [CNT_W-1:0]  Z_RESET    = CNT_W'(256);

    typedef enum logic [1:0] {
        FUNC_STEP   = 2'd0,
        FUNC_LOAD   = 2'd1,
        FUNC_INTERP = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE    = 2'd0,
        CFG_X_COUNT = 2'd1,
        CFG_Z_COUNT = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POS,
        ST_SQUARE,
        ST_CUBE,
        ST_WEIGHT,
        ST_COMMIT
    } step_state_t;

    typedef struct packed {
        func_t                         func;
        logic [H_W-1:0]                half_step;
        logic [CH_W-1:0]               channel;
        logic [TAP_W-1:0]              tap;
        logic signed [SAMPLE_BITS-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic                          need_frame;
        logic                          in_phase;
        logic signed [SAMPLE_BITS-1:0] value;
    } out_item_t;

    typedef struct packed {
        func_t                         func;
        logic                          need_frame;
        logic [CH_W-1:0]               channel;
        logic [TAP_W-1:0]              tap;
        logic signed [SAMPLE_BITS-1:0] sample;
    } q_entry_t;

    typedef struct packed {
        logic [BND_W-1:0] b_x;
        logic [BND_W-1:0] b_3x;
        logic [BND_W-1:0] b_4xz;
        logic [BND_W-1:0] b_4x3z;
        logic [BND_W-1:0] b_4x4z;
    } bounds_t;

    typedef struct packed {
        logic [TAP_W-1:0]            ring_base;
        logic                        phase;
        logic [TAPS-1:0][W_W-1:0]    weights;
        bounds_t                     bounds;
    } ctx_t;

    function automatic bounds_t bounds_of(input logic [CNT_W-1:0] x, input logic [CNT_W-1:0] z);
        logic [BND_W-1:0] xe;
        logic [BND_W-1:0] ze;
        bounds_t          b;
        xe       = BND_W'(x);
        ze       = BND_W'(z);
        b.b_x    = xe;
        b.b_3x   = xe + (xe << 1);
        b.b_4xz  = (xe << 2) + ze;
        b.b_4x3z = (xe << 2) + ze + (ze << 1);
        b.b_4x4z = (xe << 2) + (ze << 2);
        return b;
    endfunction

endpackage

// ===== rtl/scti_front.sv =====
// Front end: item intake, configuration registers and step weight engine.
module scti_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  scti_pkg::in_item_t            s_item,
    input  logic                          cfg_we,
    input  logic [scti_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [scti_pkg::CFG_W-1:0]    cfg_wdata,
    output logic                          q_push,
    output scti_pkg::q_entry_t            q_push_entry,
    input  logic                          q_full,
    input  logic                          q_empty,
    input  logic                          back_busy,
    output scti_pkg::ctx_t                ctx
);
    import scti_pkg::*;

    localparam int POS_W = H_W + RATE_W;
    localparam int FR_W  = 16;
    localparam int SQ_W  = 2 * FR_W;
    localparam int CU_W  = 3 * FR_W;
    localparam int WQ_W  = 54;
    localparam logic signed [WQ_W-1:0] ONE_Q49  = WQ_W'(1) <<< 49;
    localparam logic signed [WQ_W-1:0] HALF_Q33 = WQ_W'(1) <<< 32;

    step_state_t                 state_reg, state_next;
    logic [H_W-1:0]              h_reg;
    logic [POS_W-1:0]            pos_reg, pos_next;
    logic [POS_W-1:0]            pos_prev;
    logic [FR_W-1:0]             frac_reg;
    logic [SQ_W-1:0]             sq_reg;
    logic [CU_W-1:0]             cube_reg;
    logic                        rot_reg, rot_next;
    logic [TAPS-1:0][W_W-1:0]    wpend_reg, wpend_next;
    logic [TAPS-1:0][W_W-1:0]    weights_reg;
    logic [TAP_W-1:0]            ring_reg;
    logic                        phase_reg;
    logic [RATE_W-1:0]           rate_reg;
    logic [CNT_W-1:0]            x_reg;
    logic [CNT_W-1:0]            z_reg;
    bounds_t                     bounds_reg;
    logic                        h_load;
    logic                        commit;

    logic signed [WQ_W-1:0]      t1, t2, t3;
    logic signed [WQ_W-1:0]      wq [TAPS];
    logic signed [WQ_W-1:0]      wr [TAPS];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && !q_full && s_item.func == FUNC_STEP) begin
                    state_next = ST_POS;
                end
            end
            ST_POS:    state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_CUBE;
            ST_CUBE:   state_next = ST_WEIGHT;
            ST_WEIGHT: state_next = ST_COMMIT;
            ST_COMMIT: begin
                if (q_empty && !back_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        q_push       = 1'b0;
        h_load       = 1'b0;
        commit       = 1'b0;
        q_push_entry.func       = s_item.func;
        q_push_entry.need_frame = 1'b0;
        q_push_entry.channel    = s_item.channel;
        q_push_entry.tap        = s_item.tap;
        q_push_entry.sample     = s_item.sample;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = !q_full;
                if (s_valid && !q_full) begin
                    if (s_item.func == FUNC_STEP) begin
                        h_load = 1'b1;
                    end else begin
                        q_push = 1'b1;
                    end
                end
            end
            ST_COMMIT: begin
                commit                  = q_empty && !back_busy;
                q_push                  = commit;
                q_push_entry.func       = FUNC_STEP;
                q_push_entry.need_frame = rot_reg;
            end
            default: begin
            end
        endcase
    end

    assign pos_next = POS_W'(h_reg) * POS_W'(rate_reg);
    assign pos_prev = pos_reg - POS_W'(rate_reg);
    assign rot_next = (h_reg != '0) && (pos_reg[POS_W-1:17] != pos_prev[POS_W-1:17]);

    always_comb begin
        t1 = $signed(WQ_W'(frac_reg));
        t2 = $signed(WQ_W'(sq_reg));
        t3 = $signed(WQ_W'(cube_reg));
        wq[0] = -t3 + (t2 <<< 17) - (t1 <<< 32);
        wq[1] = (t3 <<< 1) + t3 - (t2 <<< 18) - (t2 <<< 16) + ONE_Q49;
        wq[2] = -(t3 <<< 1) - t3 + (t2 <<< 18) + (t1 <<< 32);
        wq[3] = t3 - (t2 <<< 16);
        for (int j = 0; j < TAPS; j++) begin
            wr[j]         = (wq[j] + HALF_Q33) >>> 33;
            wpend_next[j] = wr[j][W_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (h_load) begin
            h_reg <= s_item.half_step;
        end
        if (state_reg == ST_POS) begin
            pos_reg <= pos_next;
        end
        if (state_reg == ST_SQUARE) begin
            frac_reg <= pos_reg[FR_W:1];
            sq_reg   <= SQ_W'(pos_reg[FR_W:1]) * SQ_W'(pos_reg[FR_W:1]);
            rot_reg  <= rot_next;
        end
        if (state_reg == ST_CUBE) begin
            cube_reg <= CU_W'(sq_reg) * CU_W'(frac_reg);
        end
        if (state_reg == ST_WEIGHT) begin
            wpend_reg <= wpend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            weights_reg <= '0;
            ring_reg    <= '0;
            phase_reg   <= 1'b0;
            rate_reg    <= RATE_RESET;
            x_reg       <= X_RESET;
            z_reg       <= Z_RESET;
            bounds_reg  <= bounds_of(X_RESET, Z_RESET);
        end else begin
            state_reg  <= state_next;
            bounds_reg <= bounds_of(x_reg, z_reg);
            if (commit) begin
                weights_reg <= wpend_reg;
                ring_reg    <= ring_reg + TAP_W'(rot_reg);
                phase_reg   <= h_reg[0];
            end
            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_addr))
                    CFG_RATE:    rate_reg <= cfg_wdata[RATE_W-1:0];
                    CFG_X_COUNT: x_reg    <= cfg_wdata[CNT_W-1:0];
                    CFG_Z_COUNT: z_reg    <= cfg_wdata[CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign ctx.ring_base = ring_reg;
    assign ctx.phase     = phase_reg;
    assign ctx.weights   = weights_reg;
    assign ctx.bounds    = bounds_reg;

endmodule

// ===== rtl/scti_queue.sv =====
// Short flop queue of classified items between front and back.
module scti_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  scti_pkg::q_entry_t push_entry,
    input  logic               pop,
    output scti_pkg::q_entry_t pop_entry,
    output logic               empty,
    output logic               full
);
    import scti_pkg::*;

    localparam int Q_AW = $clog2(QUEUE_DEPTH);

    q_entry_t          slots_reg [QUEUE_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW:0]     count_reg, count_next;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == (Q_AW + 1)'(QUEUE_DEPTH));
    assign pop_entry = slots_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/scti_back.sv =====
// Back end: banked tap memories, four-tap multiply-accumulate and result register.
module scti_back #(
    parameter int CHANNELS = scti_pkg::CHANNELS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    output logic                q_pop,
    input  scti_pkg::q_entry_t  q_entry,
    input  scti_pkg::ctx_t      ctx,
    output logic                busy,
    output logic                m_valid,
    input  logic                m_ready,
    output scti_pkg::out_item_t m_item
);
    import scti_pkg::*;

    localparam int AW     = $clog2(CHANNELS);
    localparam int PROD_W = W_W + SAMPLE_BITS;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic signed [SUM_W-1:0] SMP_MAX  = SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SMP_MIN  = -SMP_MAX - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] HALF_Q16 = SUM_W'(1) <<< 15;

    logic                          adv;
    logic [CH_EXT_W-1:0]           ch_ext;
    logic                          ch_ok;
    logic [AW-1:0]                 addr;
    logic [TAP_W-1:0]              wr_slot;
    logic                          wr_en;
    logic                          rd_en;
    logic [BND_W-1:0]              ch_b;
    logic                          ph0, ph1, hit;

    logic                          s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    func_t                         s1_func_reg, s2_func_reg, s3_func_reg;
    logic                          s1_need_reg, s2_need_reg, s3_need_reg;
    logic                          s1_hit_reg, s2_hit_reg, s3_hit_reg;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg [TAPS];
    logic signed [PROD_W-1:0]      prod_reg [TAPS];
    logic signed [PROD_W-1:0]      prod_next [TAPS];
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic signed [SUM_W-1:0]       rounded;
    logic signed [SAMPLE_BITS-1:0] sat_value;
    out_item_t                     out_reg, out_next;

    assign adv   = !out_valid_reg || m_ready;
    assign q_pop = adv && !q_empty;
    assign busy  = s1_valid_reg || s2_valid_reg || s3_valid_reg;

    assign ch_ext  = CH_EXT_W'(q_entry.channel);
    assign ch_ok   = ch_ext < CH_EXT_W'(CHANNELS);
    assign addr    = ch_ext[AW-1:0];
    assign wr_slot = ctx.ring_base + q_entry.tap;
    assign wr_en   = q_pop && q_entry.func == FUNC_LOAD && ch_ok;
    assign rd_en   = q_pop && q_entry.func == FUNC_INTERP;

    assign ch_b = BND_W'(q_entry.channel);
    assign ph0  = (ch_b < ctx.bounds.b_x)
               || (ch_b >= ctx.bounds.b_3x && ch_b < ctx.bounds.b_4xz)
               || (ch_b >= ctx.bounds.b_4x3z && ch_b < ctx.bounds.b_4x4z);
    assign ph1  = (ch_b >= ctx.bounds.b_x && ch_b < ctx.bounds.b_3x)
               || (ch_b >= ctx.bounds.b_4xz && ch_b < ctx.bounds.b_4x3z);
    assign hit  = q_entry.func == FUNC_INTERP && ch_ok && (ctx.phase ? ph1 : ph0);

    for (genvar b = 0; b < TAPS; b++) begin : g_bank
        logic signed [SAMPLE_BITS-1:0] bank_mem [CHANNELS];
        always_ff @(posedge aclk) begin
            if (wr_en && wr_slot == TAP_W'(b)) begin
                bank_mem[addr] <= q_entry.sample;
            end
            if (rd_en) begin
                rd_data_reg[b] <= bank_mem[addr];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < TAPS; j++) begin
            prod_next[j] = PROD_W'($signed(ctx.weights[j]))
                         * PROD_W'(rd_data_reg[ctx.ring_base + TAP_W'(j)]);
        end
        sum_next = '0;
        for (int j = 0; j < TAPS; j++) begin
            sum_next = sum_next + SUM_W'(prod_reg[j]);
        end
        rounded = (sum_reg + HALF_Q16) >>> 16;
        if (rounded > SMP_MAX) begin
            sat_value = SMP_MAX[SAMPLE_BITS-1:0];
        end else if (rounded < SMP_MIN) begin
            sat_value = SMP_MIN[SAMPLE_BITS-1:0];
        end else begin
            sat_value = rounded[SAMPLE_BITS-1:0];
        end
        out_next.need_frame = s3_func_reg == FUNC_STEP && s3_need_reg;
        out_next.in_phase   = s3_hit_reg;
        out_next.value      = s3_hit_reg ? sat_value : '0;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_func_reg <= q_entry.func;
            s1_need_reg <= q_entry.need_frame;
            s1_hit_reg  <= hit;
            s2_func_reg <= s1_func_reg;
            s2_need_reg <= s1_need_reg;
            s2_hit_reg  <= s1_hit_reg;
            prod_reg    <= prod_next;
            s3_func_reg <= s2_func_reg;
            s3_need_reg <= s2_need_reg;
            s3_hit_reg  <= s2_hit_reg;
            sum_reg     <= sum_next;
            out_reg     <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= q_pop;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

// ===== rtl/staggered_cubic_time_interpolator.sv =====
// Top level of the staggered cubic time interpolator.
// Load, interpolate and unused items are taken one per cycle while the
// four-entry queue has room. Each leaves the queue after it is taken and
// reaches the result register through the memory read at the pop, then tap
// multiply, sum, and round and saturate. After a step item is taken the input
// stays closed through the position multiply, square, cube, weight and commit
// stages of the front end, and longer while the back end drains: new weights
// and ring position take effect only once the queue is empty and every earlier
// item has reached the result register. Samples sit in four memory banks, one
// per ring slot, each CHANNELS deep; they need no clearing after reset, and a
// tap read before it was ever loaded returns an arbitrary value.
module staggered_cubic_time_interpolator #(
    parameter int CHANNELS = scti_pkg::CHANNELS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  scti_pkg::in_item_t             s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output scti_pkg::out_item_t            m_item,
    input  logic                           cfg_we,
    input  logic [scti_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [scti_pkg::CFG_W-1:0]     cfg_wdata
);
    import scti_pkg::*;

    logic     q_push;
    q_entry_t q_push_entry;
    logic     q_pop;
    q_entry_t q_pop_entry;
    logic     q_empty;
    logic     q_full;
    logic     back_busy;
    ctx_t     ctx;

    scti_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .q_push       (q_push),
        .q_push_entry (q_push_entry),
        .q_full       (q_full),
        .q_empty      (q_empty),
        .back_busy    (back_busy),
        .ctx          (ctx)
    );

    scti_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .pop_entry  (q_pop_entry),
        .empty      (q_empty),
        .full       (q_full)
    );

    scti_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_entry (q_pop_entry),
        .ctx     (ctx),
        .busy    (back_busy),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
